FILE: hdl/kms_pkg.sv
package kms_pkg;

  // Matrix geometry
  localparam int unsigned ROWS      = 10;
  localparam int unsigned COLS      = 8;
  localparam int unsigned ROW_W     = 4;   // row field of a key code
  localparam int unsigned COL_W     = 3;   // column field of a key code
  localparam int unsigned CODE_W    = ROW_W + COL_W;
  localparam int unsigned SEL_OUT_W = 10;  // row select as shown on the result

  // Port widths
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 24;

  // Request kinds carried on the input tuser
  typedef enum logic [1:0] {
    REQ_KEY       = 2'd0,
    REQ_LOAD_FALL = 2'd1,
    REQ_LOAD_RISE = 2'd2,
    REQ_CLK_RISE  = 2'd3
  } kms_req_e;

  typedef logic [COLS-1:0] row_t;
  typedef logic [ROWS-1:0] sel_t;

  // One accepted input item
  typedef struct packed {
    kms_req_e            req_type;
    logic [CODE_W-1:0]   key_code;
    logic                key_down;
    logic                clock_pin;
  } kms_item_t;

  // One result item
  typedef struct packed {
    logic                 ser_data;
    logic                 any_key;
    row_t                 row_data;
    logic [SEL_OUT_W-1:0] row_select;
  } kms_result_t;

  // Handshake between the input register and the core
  typedef struct packed {
    logic valid;
  } kms_flow_t;

endpackage

FILE: hdl/key_matrix_serial_scanner.sv
// Keyboard matrix emulator with a serial row scanner. Each input item is one
// event: a key change (tuser 0), a load falling edge (1), a load rising edge
// (2) or a clock rising edge (3); every item returns exactly one result with
// the serial data bit, the any-key flag, the OR of the selected rows and the
// row-select mask, all taken after the event. An item passes an input
// register and then the matrix update into a result register, so the block
// takes one item per clock while results are taken; a result is valid once
// its item has moved from the input into the result register; a stalled result
// holds one item in each register. Reset clears the key bitmap and sets all rows selected.
module key_matrix_serial_scanner (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [kms_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // key_code[6:0], key_down, clock_pin
  input  logic [kms_pkg::IN_USER_W-1:0]  s_axis_tuser,  // req_type[1:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [kms_pkg::OUT_DATA_W-1:0] m_axis_tdata   // ser_data, any_key, row_data[7:0],
                                                        // row_select[9:0]
);

  kms_pkg::kms_item_t   item;
  kms_pkg::kms_flow_t   flow;
  kms_pkg::kms_result_t res;
  logic                 in_valid;
  logic                 advance;

  kms_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .advance_i     (advance),
    .valid_o       (in_valid),
    .item_o        (item)
  );

  assign flow.valid = in_valid;

  kms_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .flow_i      (flow),
    .item_i      (item),
    .res_ready_i (m_axis_tready),
    .res_valid_o (m_axis_tvalid),
    .advance_o   (advance),
    .res_o       (res)
  );

  // Pack result fields from the low bit up
  assign m_axis_tdata = {4'b0000, res.row_select, res.row_data, res.any_key, res.ser_data};

endmodule

FILE: hdl/kms_in_reg.sv
module kms_in_reg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [kms_pkg::IN_DATA_W-1:0] s_axis_tdata,  // key_code[6:0], key_down, clock_pin
  input  logic [kms_pkg::IN_USER_W-1:0] s_axis_tuser,  // req_type[1:0]
  input  logic                         advance_i,
  output logic                         valid_o,
  output kms_pkg::kms_item_t           item_o
);

  logic               vld_q, vld_d;
  kms_pkg::kms_item_t item_q, item_d;
  logic               take;

  // Free when empty or when the held item moves on this cycle
  assign s_axis_tready = !vld_q || advance_i;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    vld_d  = vld_q;
    item_d = item_q;
    if (take) begin
      vld_d              = 1'b1;
      item_d.req_type    = kms_pkg::kms_req_e'(s_axis_tuser[1:0]);
      item_d.key_code    = s_axis_tdata[kms_pkg::CODE_W-1:0];
      item_d.key_down    = s_axis_tdata[kms_pkg::CODE_W];
      item_d.clock_pin   = s_axis_tdata[kms_pkg::CODE_W+1];
    end else if (advance_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

endmodule

FILE: hdl/kms_core.sv
module kms_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kms_pkg::kms_flow_t    flow_i,
  input  kms_pkg::kms_item_t    item_i,
  input  logic                  res_ready_i,
  output logic                  res_valid_o,
  output logic                  advance_o,
  output kms_pkg::kms_result_t  res_o
);

  kms_pkg::row_t [kms_pkg::ROWS-1:0] bitmap_q;
  kms_pkg::row_t [kms_pkg::ROWS-1:0] bitmap_d;
  kms_pkg::sel_t        sel_q, sel_d;
  kms_pkg::row_t        buf_q, buf_d;
  kms_pkg::row_t        shift_q, shift_d;
  logic                 data_q, data_d;
  logic                 any_q, any_d;
  logic                 out_vld_q;
  kms_pkg::kms_result_t res_q, res_d;
  kms_pkg::row_t        sel_rows;
  logic                 advance;

  // Move the held item into the result register when it is free
  assign advance   = flow_i.valid && (!out_vld_q || res_ready_i);
  assign advance_o = advance;

  // Next state for one item
  always_comb begin
    logic [kms_pkg::ROW_W-1:0]     row;
    logic [kms_pkg::COL_W-1:0]     col;
    kms_pkg::row_t                 bit_mask;
    logic [kms_pkg::ROWS+kms_pkg::SEL_OUT_W-1:0] sel_ext;

    row      = item_i.key_code[kms_pkg::ROW_W-1:0];
    col      = item_i.key_code[kms_pkg::CODE_W-1:kms_pkg::ROW_W];
    bit_mask = kms_pkg::row_t'(1) << col;

    for (int r = 0; r < kms_pkg::ROWS; r++) begin
      bitmap_d[r] = bitmap_q[r];
    end
    sel_d   = sel_q;
    buf_d   = buf_q;
    shift_d = shift_q;
    data_d  = data_q;

    unique case (item_i.req_type)
      kms_pkg::REQ_KEY: begin
        // Rows past the matrix fall through every compare
        for (int r = 0; r < kms_pkg::ROWS; r++) begin
          if (row == kms_pkg::ROW_W'(r)) begin
            bitmap_d[r] = item_i.key_down ? (bitmap_q[r] | bit_mask)
                                          : (bitmap_q[r] & ~bit_mask);
          end
        end
      end
      kms_pkg::REQ_LOAD_FALL: begin
        shift_d = buf_q;
      end
      kms_pkg::REQ_LOAD_RISE: begin
        sel_d = {sel_q[kms_pkg::ROWS-2:0], ~item_i.clock_pin};
      end
      kms_pkg::REQ_CLK_RISE: begin
        shift_d = {shift_q[kms_pkg::COLS-2:0], 1'b1};
        data_d  = shift_q[kms_pkg::COLS-2];
      end
      default: begin
      end
    endcase

    // OR of the selected rows after the update
    sel_rows = '0;
    for (int r = 0; r < kms_pkg::ROWS; r++) begin
      if (sel_d[r]) sel_rows = sel_rows | bitmap_d[r];
    end

    if (item_i.req_type == kms_pkg::REQ_LOAD_RISE) begin
      buf_d = sel_rows;
    end
    any_d = any_q;
    if (item_i.req_type == kms_pkg::REQ_KEY ||
        item_i.req_type == kms_pkg::REQ_LOAD_RISE) begin
      any_d = |sel_rows;
    end

    sel_ext          = {{kms_pkg::SEL_OUT_W{1'b0}}, sel_d};
    res_d.ser_data   = data_d;
    res_d.any_key    = any_d;
    res_d.row_data   = sel_rows;
    res_d.row_select = sel_ext[kms_pkg::SEL_OUT_W-1:0];
  end

  // Matrix state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < kms_pkg::ROWS; r++) begin
        bitmap_q[r] <= '0;
      end
      sel_q     <= '1;
      buf_q     <= '0;
      shift_q   <= '0;
      data_q    <= 1'b0;
      any_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        for (int r = 0; r < kms_pkg::ROWS; r++) begin
          bitmap_q[r] <= bitmap_d[r];
        end
        sel_q   <= sel_d;
        buf_q   <= buf_d;
        shift_q <= shift_d;
        data_q  <= data_d;
        any_q   <= any_d;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = res_q;

  // Row select moves only on a load rising edge
  a_sel_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && item_i.req_type == kms_pkg::REQ_LOAD_RISE) |=> $stable(sel_q))
    else $error("row select changed without a load rise");

  // Bitmap moves only on a key event
  a_map_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && item_i.req_type == kms_pkg::REQ_KEY) |=> $stable(bitmap_q))
    else $error("key bitmap changed without a key event");

  // After a key event the any-key flag agrees with the row OR
  a_any_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_i.req_type == kms_pkg::REQ_KEY) |=>
      (res_q.any_key == (|res_q.row_data)))
    else $error("any_key disagrees with row data");

  // Shifter only moves on load fall or clock rise
  a_shift_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && (item_i.req_type == kms_pkg::REQ_LOAD_FALL ||
                  item_i.req_type == kms_pkg::REQ_CLK_RISE)) |=> $stable(shift_q))
    else $error("shifter changed unexpectedly");

endmodule
